// ===== rtl/base91_stream_encoder_top_assert.svh =====
// Assertion macros for the basE91 stream encoder.
// Used by the top level only; needs nothing else.
`ifndef BASE91_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE91_STREAM_ENCODER_TOP_ASSERT_SVH

// a implies b in the same cycle
`define B91_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("b91enc: same-cycle check failed");

// a implies b in the next cycle
`define B91_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("b91enc: next-cycle check failed");

`endif

// ===== rtl/b91enc_pkg.sv =====
// Package of the basE91 stream encoder: payload and job types, constants,
// alphabet lookup. No dependencies.
`default_nettype none

package b91enc_pkg;

  localparam int unsigned QBITS      = 13;
  localparam int unsigned CBITS      = 4;
  localparam int unsigned VBITS      = 14;
  localparam int unsigned DIV_SHIFT  = 20;
  localparam logic [13:0] RECIP_91   = 14'd11523;  // ceil(2^20 / 91)
  localparam logic [6:0]  RADIX      = 7'd91;
  localparam logic [12:0] SHORT_MAX  = 13'd88;
  localparam logic [12:0] SINGLE_MAX = 13'd90;
  localparam logic [15:0] CAP_RESET  = 16'hFFFF;

  localparam int unsigned ITEM_V_MOD = 0;
  localparam int unsigned ITEM_V_DIV = 1;
  localparam int unsigned ITEM_Q_MOD = 2;
  localparam int unsigned ITEM_Q_DIV = 3;
  localparam int unsigned ITEM_ERR   = 4;
  localparam int unsigned NITEMS     = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        last_symbol;
    logic        overflow;
    logic [15:0] char_count;
  } out_t;

  typedef struct packed {
    logic [15:0] max_output_chars;
  } cfg_t;

  typedef struct packed {
    logic             has_pair;
    logic [VBITS-1:0] v;
    logic [1:0]       flush_n;
    logic [QBITS-1:0] q;
    logic             err;
    logic             last;
    logic [15:0]      count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] ALPHABET [0:90] = '{
    "A","B","C","D","E","F","G","H","I","J","K","L","M",
    "N","O","P","Q","R","S","T","U","V","W","X","Y","Z",
    "a","b","c","d","e","f","g","h","i","j","k","l","m",
    "n","o","p","q","r","s","t","u","v","w","x","y","z",
    "0","1","2","3","4","5","6","7","8","9","!","#","$",
    "%","&","(",")","*","+",",",".","/",":",";","<","=",
    ">","?","@","[","]","^","_",8'h60,"{","|","}","~","-"
  };

  function automatic logic [7:0] sym_of(input logic [7:0] idx);
    logic [7:0] s;
    s = 8'd0;
    if (idx < {1'b0, RADIX}) begin
      s = ALPHABET[idx[6:0]];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b91enc_byte_if.sv =====
// Byte input channel of the basE91 stream encoder.
// Depends on b91enc_pkg.
`default_nettype none

interface b91enc_byte_if;
  logic             valid;
  logic             ready;
  b91enc_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/b91enc_sym_if.sv =====
// Symbol output channel of the basE91 stream encoder.
// Depends on b91enc_pkg.
`default_nettype none

interface b91enc_sym_if;
  logic             valid;
  logic             ready;
  b91enc_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/b91enc_cfg_if.sv =====
// Configuration write channel of the basE91 stream encoder.
// Depends on b91enc_pkg.
`default_nettype none

interface b91enc_cfg_if;
  logic             valid;
  logic             ready;
  b91enc_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/base91_stream_encoder_top.sv =====
// Top level of the basE91 stream encoder: capacity register, front end,
// job queue, back end. Depends on b91enc_pkg, the channel interfaces, all
// b91enc_* modules and base91_stream_encoder_top_assert.svh.
//
// Usage:
//   byte_ch takes one message byte per beat, last_byte on the final one.
//   sym_ch gives one character per beat; the final beat of a message has
//   last_symbol and the character total in char_count. On capacity
//   overflow one beat with overflow set ends the message and the rest of
//   its bytes are dropped.
//   cfg_ch writes max_output_chars (reset 65535); write it only while idle.
// Timing:
//   A byte is taken every cycle while the job queue has room. Its job
//   passes the queue and the back end's job register before its first
//   character leaves the output register. The back end sends one
//   character per cycle unless sym_ch stalls; about 1.2 per byte sustained.
// Reset and stall:
//   Synchronous reset empties the queue and clears the bit queue, counters
//   and discard state. When sym_ch stalls, the output register holds, the
//   back end waits and the queue fills; byte_ch ready drops only when full.
`default_nettype none

module base91_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b91enc_byte_if.sink byte_ch,
  b91enc_sym_if.source sym_ch,
  b91enc_cfg_if.sink  cfg_ch
);

  logic [15:0]           max_chars;
  logic                  push;
  logic                  pop;
  b91enc_pkg::job_t      push_job;
  b91enc_pkg::job_t      head;
  b91enc_pkg::q_status_t q_stat;
  logic                  ovf_beat;
  logic                  ovf_beat_ok;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= b91enc_pkg::CAP_RESET;
    end else if (cfg_ch.valid) begin
      max_chars <= cfg_ch.payload.max_output_chars;
    end
  end

  b91enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .max_chars (max_chars),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  b91enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  b91enc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .sym_ch (sym_ch)
  );

  assign ovf_beat = sym_ch.valid && sym_ch.payload.overflow;
  assign ovf_beat_ok = sym_ch.payload.last_symbol && (sym_ch.payload.symbol == 8'd0) &&
                       (sym_ch.payload.char_count == 16'd0);

`include "base91_stream_encoder_top_assert.svh"

  `B91_ASSERT_SAME(a_no_push_full, clk, rst, push, !q_stat.full)
  `B91_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !q_stat.empty)
  `B91_ASSERT_SAME(a_ovf_beat, clk, rst, ovf_beat, ovf_beat_ok)
  `B91_ASSERT_NEXT(a_queue_fill, clk, rst, push && !pop, !q_stat.empty)

endmodule

`default_nettype wire

// ===== rtl/b91enc_front.sv =====
// Front end: takes byte beats, updates the bit queue, checks capacity and
// pushes one job per byte that yields results. Depends on b91enc_pkg.
`default_nettype none

module b91enc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  b91enc_byte_if.sink                byte_ch,
  input  wire logic [15:0]           max_chars,
  input  wire b91enc_pkg::q_status_t q_stat,
  output logic                       push,
  output b91enc_pkg::job_t           job
);

  logic [b91enc_pkg::QBITS-1:0] bit_queue;
  logic [b91enc_pkg::CBITS-1:0] bit_count;
  logic [15:0]                  chars_emitted;
  logic                         discarding;

  logic        accept;
  logic [20:0] qa;
  logic [4:0]  ca;
  logic        extract, wide;
  logic [b91enc_pkg::QBITS-1:0] rem_q;
  logic [b91enc_pkg::CBITS-1:0] rem_c;
  logic [16:0] limit, ce1;
  logic        pair_fail, flush, two, f1_fail, f2_fail, fail;
  logic [1:0]  flush_n;
  logic [16:0] ce_final;
  logic        produce;

  assign byte_ch.ready = !q_stat.full;
  assign accept = byte_ch.valid && byte_ch.ready;

  always_comb begin
    qa = {8'd0, bit_queue} | (21'(byte_ch.payload.data_byte) << bit_count);
    ca = 5'(bit_count) + 5'd8;
    extract = ca > 5'd13;
    wide = qa[12:0] <= b91enc_pkg::SHORT_MAX;
    if (!extract) begin
      rem_q = qa[12:0];
      rem_c = ca[3:0];
    end else if (wide) begin
      rem_q = 13'(qa[20:14]);
      rem_c = 4'(ca - 5'd14);
    end else begin
      rem_q = 13'(qa[20:13]);
      rem_c = 4'(ca - 5'd13);
    end

    limit = (max_chars == 16'd0) ? 17'd0 : 17'(max_chars) - 17'd1;
    pair_fail = extract && (17'(chars_emitted) + 17'd2 > limit);
    ce1 = extract ? 17'(chars_emitted) + 17'd2 : 17'(chars_emitted);
    flush = byte_ch.payload.last_byte && (rem_c != '0) && !pair_fail;
    two = (rem_c > 4'd7) || (rem_q > b91enc_pkg::SINGLE_MAX);
    f1_fail = flush && (ce1 + 17'd1 > limit);
    f2_fail = flush && !f1_fail && two && (ce1 + 17'd2 > limit);
    fail = pair_fail || f1_fail || f2_fail;
    if (flush && !f1_fail) begin
      flush_n = (two && !f2_fail) ? 2'd2 : 2'd1;
    end else begin
      flush_n = 2'd0;
    end
    ce_final = ce1 + 17'(flush_n);

    job.has_pair = extract && !pair_fail;
    job.v        = wide ? qa[13:0] : {1'b0, qa[12:0]};
    job.flush_n  = flush_n;
    job.q        = rem_q;
    job.err      = fail;
    job.last     = byte_ch.payload.last_byte;
    job.count    = ce_final[15:0];

    produce = job.has_pair || (flush_n != 2'd0) || fail;
    push = accept && !discarding && produce;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_queue <= '0;
      bit_count <= '0;
      chars_emitted <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      if (discarding) begin
        if (byte_ch.payload.last_byte) begin
          discarding <= 1'b0;
          bit_queue <= '0;
          bit_count <= '0;
          chars_emitted <= '0;
        end
      end else if (fail || byte_ch.payload.last_byte) begin
        bit_queue <= '0;
        bit_count <= '0;
        chars_emitted <= '0;
        discarding <= fail && !byte_ch.payload.last_byte;
      end else begin
        bit_queue <= rem_q;
        bit_count <= rem_c;
        chars_emitted <= ce1[15:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b91enc_fifo.sv =====
// Short job queue between front and back end.
// Depends on b91enc_pkg.
`default_nettype none

module b91enc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire b91enc_pkg::job_t       push_job,
  input  wire logic                   pop,
  output b91enc_pkg::job_t            head,
  output b91enc_pkg::q_status_t       q_stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b91enc_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head = mem[rd_ptr];
  assign q_stat.full = fill == CNT_W'(DEPTH);
  assign q_stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b91enc_back.sv =====
// Back end: loads jobs with quotients by 91, emits one symbol beat per
// cycle via an output register unless sym_ch stalls. Needs b91enc_pkg.
`default_nettype none

module b91enc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire b91enc_pkg::job_t      head,
  input  wire b91enc_pkg::q_status_t q_stat,
  output logic                       pop,
  b91enc_sym_if.source               sym_ch
);

  localparam int unsigned N = b91enc_pkg::NITEMS;

  b91enc_pkg::job_t cur;
  logic [7:0]       cur_qv;
  logic [6:0]       cur_qq;
  logic [N-1:0]     cur_mask;
  logic             cur_valid;

  logic             sym_valid;
  b91enc_pkg::out_t sym_data;

  logic [27:0]  prod_v;
  logic [26:0]  prod_q;
  logic [N-1:0] init_mask;
  logic [14:0]  mul_v;
  logic [13:0]  mul_q;
  logic [13:0]  rv;
  logic [12:0]  rq;
  logic [N-1:0] sel, mask_next;
  logic [7:0]   idx;
  logic         is_err, fin, emit;
  b91enc_pkg::out_t item;

  assign prod_v = 28'(head.v) * 28'(b91enc_pkg::RECIP_91);
  assign prod_q = 27'(head.q) * 27'(b91enc_pkg::RECIP_91);

  always_comb begin
    init_mask = '0;
    init_mask[b91enc_pkg::ITEM_V_MOD] = head.has_pair;
    init_mask[b91enc_pkg::ITEM_V_DIV] = head.has_pair;
    init_mask[b91enc_pkg::ITEM_Q_MOD] = head.flush_n != 2'd0;
    init_mask[b91enc_pkg::ITEM_Q_DIV] = head.flush_n == 2'd2;
    init_mask[b91enc_pkg::ITEM_ERR]   = head.err;
  end

  always_comb begin
    mul_v = 15'(cur_qv) * 15'(b91enc_pkg::RADIX);
    mul_q = 14'(cur_qq) * 14'(b91enc_pkg::RADIX);
    rv = cur.v - mul_v[13:0];
    rq = cur.q - mul_q[12:0];
    sel = cur_mask & (~cur_mask + 1'b1);
    mask_next = cur_mask & ~sel;
    is_err = sel[b91enc_pkg::ITEM_ERR];
    if (sel[b91enc_pkg::ITEM_V_MOD]) begin
      idx = 8'(rv[6:0]);
    end else if (sel[b91enc_pkg::ITEM_V_DIV]) begin
      idx = cur_qv;
    end else if (sel[b91enc_pkg::ITEM_Q_MOD]) begin
      idx = 8'(rq[6:0]);
    end else begin
      idx = 8'(cur_qq);
    end
    fin = (mask_next == '0) && (cur.last || cur.err);
    item.symbol      = is_err ? 8'd0 : b91enc_pkg::sym_of(idx);
    item.last_symbol = fin;
    item.overflow    = is_err;
    item.char_count  = (fin && !is_err) ? cur.count : 16'd0;
  end

  assign emit = cur_valid && (!sym_valid || sym_ch.ready);
  assign pop = !q_stat.empty && (!cur_valid || (emit && mask_next == '0));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cur_qv <= prod_v[b91enc_pkg::DIV_SHIFT +: 8];
      cur_qq <= prod_q[b91enc_pkg::DIV_SHIFT +: 7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_mask <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      cur_mask <= init_mask;
    end else if (emit) begin
      cur_mask <= mask_next;
      if (mask_next == '0) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (emit) begin
      sym_valid <= 1'b1;
    end else if (sym_ch.ready) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sym_data <= item;
    end
  end

  assign sym_ch.valid = sym_valid;
  assign sym_ch.payload = sym_data;

endmodule

`default_nettype wire

// ===== tb/tb_base91_stream_encoder_top.sv =====
// Self-checking testbench for base91_stream_encoder_top: random and directed
// byte messages against an in-bench basE91 encoder, with capacity overflows.
// Depends on b91enc_pkg, the three channel interfaces and the RTL top level.
`default_nettype none

module tb_base91_stream_encoder_top;

  localparam int BASE        = 91;
  localparam int SHORT_LIMIT = 88;
  localparam int SINGLE_TOP  = 90;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 24;
  localparam int LIMIT       = 400000;
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst;

  always #1 clk = ~clk;

  b91enc_byte_if byte_ch ();
  b91enc_sym_if  sym_ch ();
  b91enc_cfg_if  cfg_ch ();

  base91_stream_encoder_top DUT (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_ch),
    .sym_ch (sym_ch),
    .cfg_ch (cfg_ch)
  );

  // encoder state as the block should hold it
  logic [20:0] acc_bits;
  logic [4:0]  acc_n;
  logic [15:0] msg_chars;
  logic        dropping;
  logic [15:0] cap;

  b91enc_pkg::in_t  pending [$];
  b91enc_pkg::out_t symbols_due [$];

  int errors = 0;
  int fed_items = 0;
  int symbols_checked = 0;
  int aborts = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  bit byte_taken = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic logic [7:0] glyph(input int idx);
    string punct;
    string tail;
    punct = "!#$%&()*+,./:;<=>?@[]^_";
    tail = "{|}~-";
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx < 85) return punct[idx - 62];
    if (idx == 85) return 8'h60;
    if (idx < BASE) return tail[idx - 86];
    return 8'h00;
  endfunction

  task automatic encode_byte(input logic [7:0] data, input logic last);
    int limit;
    int nc;
    int digit [4];
    logic [13:0] v;
    logic fail;
    b91enc_pkg::out_t r;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        acc_bits = '0;
        acc_n = '0;
        msg_chars = '0;
      end
      return;
    end
    fed_items++;
    limit = (cap == 16'd0) ? 0 : int'(cap) - 1;
    nc = 0;
    fail = 1'b0;
    if (acc_n > 5'd13) acc_n = 5'd13;
    acc_bits = acc_bits | (21'(data) << acc_n);
    acc_n = acc_n + 5'd8;
    if (acc_n > 5'd13) begin
      if (int'(acc_bits[12:0]) > SHORT_LIMIT) begin
        v = {1'b0, acc_bits[12:0]};
        acc_bits = acc_bits >> 13;
        acc_n = acc_n - 5'd13;
      end else begin
        v = acc_bits[13:0];
        acc_bits = acc_bits >> 14;
        acc_n = acc_n - 5'd14;
      end
      if (int'(msg_chars) + 2 > limit) begin
        fail = 1'b1;
      end else begin
        digit[0] = int'(v) % BASE;
        digit[1] = int'(v) / BASE;
        nc = 2;
        msg_chars = msg_chars + 16'd2;
      end
    end
    if (!fail && last && acc_n > 5'd0) begin
      if (int'(msg_chars) + 1 > limit) begin
        fail = 1'b1;
      end else begin
        digit[nc] = int'(acc_bits) % BASE;
        nc++;
        msg_chars = msg_chars + 16'd1;
        if (acc_n > 5'd7 || int'(acc_bits) > SINGLE_TOP) begin
          if (int'(msg_chars) + 1 > limit) begin
            fail = 1'b1;
          end else begin
            digit[nc] = int'(acc_bits) / BASE;
            nc++;
            msg_chars = msg_chars + 16'd1;
          end
        end
      end
    end
    for (int i = 0; i < nc; i++) begin
      r.symbol = glyph(digit[i]);
      r.last_symbol = !fail && last && (i == nc - 1);
      r.overflow = 1'b0;
      r.char_count = r.last_symbol ? msg_chars : 16'd0;
      symbols_due.push_back(r);
    end
    if (fail) begin
      r.symbol = 8'h00;
      r.last_symbol = 1'b1;
      r.overflow = 1'b1;
      r.char_count = 16'd0;
      symbols_due.push_back(r);
      aborts++;
      dropping = !last;
    end
    if (fail || last) begin
      acc_bits = '0;
      acc_n = '0;
      msg_chars = '0;
    end
  endtask

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        byte_ch.valid <= 1'b1;
        byte_ch.payload <= pending.pop_front();
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  // symbol receiver, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    sym_ch.ready <= !rst && hold_left == 0 && $urandom_range(99) >= stall_pct;
  end

  // monitor: capacity writes, byte beats into the predictor, symbol checks
  always @(posedge clk) begin : monitor
    b91enc_pkg::out_t want;
    b91enc_pkg::out_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) cap = cfg_ch.payload.max_output_chars;
      if (sym_ch.valid && sym_ch.ready) begin
        got = sym_ch.payload;
        if (symbols_due.size() == 0) begin
          flag_error($sformatf("symbol beat %h with nothing outstanding", got));
        end else begin
          want = symbols_due.pop_front();
          if (got.symbol !== want.symbol)
            flag_error($sformatf("symbol: got %h, want %h", got.symbol, want.symbol));
          if (got.last_symbol !== want.last_symbol)
            flag_error($sformatf("last_symbol: got %b, want %b",
                                 got.last_symbol, want.last_symbol));
          if (got.overflow !== want.overflow)
            flag_error($sformatf("overflow: got %b, want %b", got.overflow, want.overflow));
          if (got.char_count !== want.char_count)
            flag_error($sformatf("char_count: got %0d, want %0d",
                                 got.char_count, want.char_count));
          symbols_checked++;
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        encode_byte(byte_ch.payload.data_byte, byte_ch.payload.last_byte);
        byte_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d symbols outstanding",
               cycle_count, symbols_due.size());
      $display("FAIL base91_stream_encoder_top");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] data, input logic last);
    pending.push_back('{data_byte: data, last_byte: last});
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || symbols_due.size() > 0 || byte_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload.max_output_chars <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_traffic(input int goal);
    int sent;
    int len;
    int pick;
    logic [7:0] data;
    sent = 0;
    while (sent < goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      if (len > goal - sent) len = goal - sent;
      for (int i = 0; i < len; i++) begin
        while (pending.size() > 8) @(posedge clk);
        pick = $urandom_range(7);
        data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        push_beat(data, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    acc_bits = '0;
    acc_n = '0;
    msg_chars = '0;
    dropping = 1'b0;
    cap = 16'hFFFF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte extremes, 14-bit take at and just past the threshold
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'h58, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h59, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // no room at all, abort mid-message with dropped bytes, then recovery
    write_cap(16'h0000);
    push_beat(8'hA5, 1'b1);
    push_beat(8'h3C, 1'b0);
    push_beat(8'h11, 1'b0);
    push_beat(8'h22, 1'b1);
    wait_idle();
    write_cap(16'h0001);
    push_beat(8'h00, 1'b1);
    wait_idle();
    write_cap(16'h0003);
    push_beat(8'h10, 1'b0);
    push_beat(8'h20, 1'b0);
    push_beat(8'h30, 1'b1);
    push_beat(8'h01, 1'b1);
    wait_idle();

    write_cap(16'hFFFF);
    run_traffic(100);
    wait_idle();

    send_gap_pct = 59;
    for (int k = 0; k < 4; k++) begin
      write_cap(16'($urandom_range(60, 4)));
      run_traffic(25);
      wait_idle();
    end

    send_gap_pct = 0;
    stall_pct = 59;
    write_cap(16'hFFFF);
    hold_req = 1'b1;
    run_traffic(100);
    wait_idle();

    send_gap_pct = 18;
    stall_pct = 18;
    for (int k = 0; k < 5; k++) begin
      write_cap((k == 4) ? 16'($urandom_range(20, 4)) : 16'(k));
      run_traffic(20);
      wait_idle();
    end
    write_cap(16'hFFFF);
    run_traffic(50);
    wait_idle();

    $display("covered %0d encoded bytes and %0d checked symbol beats, %0d overflow aborts,",
             fed_items, symbols_checked, aborts);
    $display("capacities from zero to full scale under four idle and stall mixes");
    if (errors == 0) begin
      $display("PASS base91_stream_encoder_top");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL base91_stream_encoder_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
